/* rtl/cbd_pkg.sv */
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the chunked body decoder
// Phase codes, status codes, register indexes and the front-to-back item.
// ----------------------------------------------------------------------------
`default_nettype none
package cbd_pkg;
  localparam int MAX_HEX_DIGITS = 16;
  localparam int SIZE_W = 53;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1) << 52;

  typedef enum logic [3:0] {
    PH_SIZE, PH_EXT, PH_DATA, PH_DATA_CR, PH_DATA_LF, PH_TRAILER, PH_DONE, PH_BAD, PH_BIG
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0, ST_DONE = 2'd1, ST_BAD = 2'd2, ST_BIG = 2'd3
  } status_t;

  localparam logic [1:0] REG_MAX_BODY = 2'd0;
  localparam logic [1:0] REG_MAX_LINE = 2'd1;
  localparam logic [1:0] REG_MAX_TRAILER = 2'd2;
  localparam logic [1:0] REG_MAX_MESSAGE = 2'd3;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;

  // Classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_body;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
    logic       is_colon;
    logic       is_lead_bad;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;
endpackage
`default_nettype wire

/* rtl/cbd_if.sv */
// ----------------------------------------------------------------------------
// cbd_in_if, cbd_out_if: valid/ready channels
// Carry a raw input byte or a per-byte result between a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none
interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_body;
  modport source (output valid, data_byte, start_of_body, input ready);
  modport sink (input valid, data_byte, start_of_body, output ready);
endinterface

interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic       body_valid;
  logic [7:0] body_byte;
  logic [1:0] status;
  modport source (output valid, body_valid, body_byte, status, input ready);
  modport sink (input valid, body_valid, body_byte, status, output ready);
endinterface
`default_nettype wire

/* rtl/cbd_front.sv */
// ----------------------------------------------------------------------------
// cbd_front: byte classifier and two-entry queue
// Accepts raw bytes, tags them and holds them for the decoder core.
// ----------------------------------------------------------------------------
`default_nettype none
module cbd_front import cbd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  cbd_in_if.sink    in_ch,
  output item_t     item,
  output logic      item_valid,
  input  wire logic item_ready
);
  item_t      q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push, pop;

  always_comb begin
    cls = '0;
    cls.data_byte = in_ch.data_byte;
    cls.start_of_body = in_ch.start_of_body;
    cls.is_cr = in_ch.data_byte == CH_CR;
    cls.is_lf = in_ch.data_byte == CH_LF;
    cls.is_semi = in_ch.data_byte == CH_SEMI;
    cls.is_colon = in_ch.data_byte == CH_COLON;
    cls.is_lead_bad = in_ch.data_byte == CH_SP || in_ch.data_byte == CH_HT ||
                      in_ch.data_byte == CH_COLON;
    if (in_ch.data_byte >= 8'h30 && in_ch.data_byte <= 8'h39) begin
      cls.is_hex = 1'b1;
      cls.hex_val = 4'(in_ch.data_byte - 8'h30);
    end else if (in_ch.data_byte >= 8'h61 && in_ch.data_byte <= 8'h66) begin
      cls.is_hex = 1'b1;
      cls.hex_val = 4'(in_ch.data_byte - 8'h57);
    end else if (in_ch.data_byte >= 8'h41 && in_ch.data_byte <= 8'h46) begin
      cls.is_hex = 1'b1;
      cls.hex_val = 4'(in_ch.data_byte - 8'h37);
    end
  end

  assign in_ch.ready = count != 2'd2;
  assign push = in_ch.valid && in_ch.ready;
  assign item_valid = count != 2'd0;
  assign pop = item_valid && item_ready;
  assign item = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/cbd_back.sv */
// ----------------------------------------------------------------------------
// cbd_back: chunk decoder core
// Runs the phase machine on one classified byte per cycle while the output is not stalled, registers result.
// ----------------------------------------------------------------------------
`default_nettype none
module cbd_back import cbd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  item_t            item,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [31:0] max_data_bytes,
  input  wire logic [15:0] max_line_bytes,
  input  wire logic [15:0] max_trailer_bytes,
  input  wire logic [31:0] max_message_bytes,
  cbd_out_if.source        out_ch
);
  phase_t            phase, phase_next, ph0;
  logic              prev_cr, prev_cr_next, prev0;
  logic [SIZE_W-1:0] acc, acc_next, acc0;
  logic [4:0]        digits, digits_next, dig0;
  logic [1:0]        perr, perr_next, perr0;
  logic [SIZE_W-1:0] remain, remain_next, rem0;
  logic [15:0]       line_len, line_len_next, len0;
  logic [31:0]       body_total, body_total_next, bt0;
  logic [31:0]       msg_total, msg_total_next, mt0;
  logic [15:0]       trl_total, trl_total_next, tt0;
  logic [1:0]        tflags, tflags_next, tf0;
  logic              ovalid, obv;
  logic [7:0]        obyte;
  logic [1:0]        ostat;
  logic              bv_next;
  logic [SIZE_W-1:0] shifted;
  logic              shift_over;
  logic [SIZE_W:0]   body_sum;
  logic              take;
  logic              c_ok;
  logic              tcount_ok;

  assign item_ready = !ovalid || out_ch.ready;
  assign take = item_valid && item_ready;

  always_comb begin
    // Start of body clears all decode state first
    ph0 = item.start_of_body ? PH_SIZE : phase;
    prev0 = item.start_of_body ? 1'b0 : prev_cr;
    acc0 = item.start_of_body ? '0 : acc;
    dig0 = item.start_of_body ? '0 : digits;
    perr0 = item.start_of_body ? '0 : perr;
    rem0 = item.start_of_body ? '0 : remain;
    len0 = item.start_of_body ? '0 : line_len;
    bt0 = item.start_of_body ? '0 : body_total;
    mt0 = item.start_of_body ? '0 : msg_total;
    tt0 = item.start_of_body ? '0 : trl_total;
    tf0 = item.start_of_body ? '0 : tflags;

    phase_next = ph0;
    prev_cr_next = prev0;
    acc_next = acc0;
    digits_next = dig0;
    perr_next = perr0;
    remain_next = rem0;
    line_len_next = len0;
    body_total_next = bt0;
    msg_total_next = mt0;
    trl_total_next = tt0;
    tflags_next = tf0;
    bv_next = 1'b0;
    shifted = {acc0[SIZE_W-5:0], 4'b0} | SIZE_W'(item.hex_val);
    shift_over = acc0[SIZE_W-1:SIZE_W-4] != 4'b0;
    body_sum = {1'b0, 21'b0, bt0} + {1'b0, acc0};
    c_ok = 1'b1;
    tcount_ok = {1'b0, tt0} + 17'd1 <= {1'b0, max_trailer_bytes};

    if (ph0 < PH_DONE) begin
      if ({1'b0, mt0} + 33'd1 > {1'b0, max_message_bytes}) begin
        phase_next = PH_BIG;
      end else begin
        msg_total_next = mt0 + 32'd1;
        case (ph0)
          PH_SIZE, PH_EXT: begin
            if (item.is_lf) begin
              if (!prev0) begin
                phase_next = PH_BAD;
              end else begin
                prev_cr_next = 1'b0;
                if (ph0 == PH_SIZE && (dig0 == 5'd0 || dig0 > 5'(MAX_HEX_DIGITS) ||
                    perr0 == 2'd1)) begin
                  phase_next = PH_BAD;
                end else if (ph0 == PH_SIZE && perr0 == 2'd2) begin
                  phase_next = PH_BIG;
                end else begin
                  acc_next = '0;
                  digits_next = '0;
                  perr_next = '0;
                  line_len_next = '0;
                  if (acc0 == '0) begin
                    phase_next = PH_TRAILER;
                    tflags_next = '0;
                  end else if (body_sum > {22'b0, max_data_bytes}) begin
                    phase_next = PH_BIG;
                  end else begin
                    remain_next = acc0;
                    phase_next = PH_DATA;
                  end
                end
              end
            end else begin
              // A held CR that was not followed by LF is a content byte
              if (prev0) begin
                prev_cr_next = 1'b0;
                if ({1'b0, len0} + 17'd1 > {1'b0, max_line_bytes}) begin
                  phase_next = PH_BIG;
                  c_ok = 1'b0;
                end else begin
                  line_len_next = len0 + 16'd1;
                  if (ph0 == PH_SIZE) begin
                    if (dig0 <= 5'(MAX_HEX_DIGITS)) digits_next = dig0 + 5'd1;
                    if (perr0 == 2'd0) perr_next = 2'd1;
                  end
                end
              end
              if (c_ok) begin
                if (item.is_cr) begin
                  prev_cr_next = 1'b1;
                end else if ({1'b0, line_len_next} + 17'd1 > {1'b0, max_line_bytes}) begin
                  phase_next = PH_BIG;
                end else begin
                  line_len_next = line_len_next + 16'd1;
                  if (ph0 == PH_SIZE) begin
                    if (item.is_semi) begin
                      if (digits_next == 5'd0 || digits_next > 5'(MAX_HEX_DIGITS) ||
                          perr_next == 2'd1) phase_next = PH_BAD;
                      else if (perr_next == 2'd2) phase_next = PH_BIG;
                      else phase_next = PH_EXT;
                    end else begin
                      if (digits_next <= 5'(MAX_HEX_DIGITS)) digits_next = digits_next + 5'd1;
                      if (!item.is_hex) begin
                        if (perr_next == 2'd0) perr_next = 2'd1;
                      end else if (perr_next == 2'd0) begin
                        // bits shifted out of the top mean the size is past the limit
                        acc_next = shifted;
                        if (shift_over || shifted > SIZE_LIMIT) perr_next = 2'd2;
                      end
                    end
                  end
                end
              end
            end
          end
          PH_DATA: begin
            if ({1'b0, bt0} + 33'd1 > {1'b0, max_data_bytes}) begin
              phase_next = PH_BIG;
            end else begin
              bv_next = 1'b1;
              body_total_next = bt0 + 32'd1;
              if (rem0 != '0) remain_next = rem0 - SIZE_W'(1);
              if (rem0 <= SIZE_W'(1)) phase_next = PH_DATA_CR;
            end
          end
          PH_DATA_CR: phase_next = item.is_cr ? PH_DATA_LF : PH_BAD;
          PH_DATA_LF: begin
            if (item.is_lf) begin
              prev_cr_next = 1'b0;
              acc_next = '0;
              digits_next = '0;
              perr_next = '0;
              line_len_next = '0;
              phase_next = PH_SIZE;
            end else begin
              phase_next = PH_BAD;
            end
          end
          default: begin
            if (item.is_lf) begin
              if (!prev0) phase_next = PH_BAD;
              else begin
                prev_cr_next = 1'b0;
                if (!tf0[0]) phase_next = PH_DONE;
                else if (!tf0[1]) phase_next = PH_BAD;
                else if (!tcount_ok) phase_next = PH_BIG;
                else begin
                  trl_total_next = tt0 + 16'd1;
                  tflags_next = '0;
                end
              end
            end else begin
              if (prev0) begin
                prev_cr_next = 1'b0;
                if (!tf0[0]) begin
                  tflags_next[0] = 1'b1;
                  if (!tcount_ok) begin
                    phase_next = PH_BIG;
                    c_ok = 1'b0;
                  end else begin
                    trl_total_next = tt0 + 16'd1;
                  end
                end
              end
              if (c_ok) begin
                if (item.is_cr) begin
                  if (tflags_next[0] &&
                      {1'b0, trl_total_next} + 17'd1 > {1'b0, max_trailer_bytes}) begin
                    phase_next = PH_BIG;
                  end else begin
                    if (tflags_next[0]) trl_total_next = trl_total_next + 16'd1;
                    prev_cr_next = 1'b1;
                  end
                end else if ({1'b0, trl_total_next} + 17'd1 >
                             {1'b0, max_trailer_bytes}) begin
                  phase_next = PH_BIG;
                end else begin
                  trl_total_next = trl_total_next + 16'd1;
                  if (!tflags_next[0]) begin
                    tflags_next[0] = 1'b1;
                    if (item.is_lead_bad) phase_next = PH_BAD;
                  end
                  if (item.is_colon) tflags_next[1] = 1'b1;
                end
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SIZE;
      prev_cr <= 1'b0;
      acc <= '0;
      digits <= '0;
      perr <= '0;
      remain <= '0;
      line_len <= '0;
      body_total <= '0;
      msg_total <= '0;
      trl_total <= '0;
      tflags <= '0;
      ovalid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        prev_cr <= prev_cr_next;
        acc <= acc_next;
        digits <= digits_next;
        perr <= perr_next;
        remain <= remain_next;
        line_len <= line_len_next;
        body_total <= body_total_next;
        msg_total <= msg_total_next;
        trl_total <= trl_total_next;
        tflags <= tflags_next;
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
    if (take) begin
      obv <= bv_next;
      obyte <= bv_next ? item.data_byte : 8'h00;
      case (phase_next)
        PH_DONE: ostat <= ST_DONE;
        PH_BAD:  ostat <= ST_BAD;
        PH_BIG:  ostat <= ST_BIG;
        default: ostat <= ST_BUSY;
      endcase
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.body_valid = obv;
  assign out_ch.body_byte = obyte;
  assign out_ch.status = ostat;
endmodule
`default_nettype wire

/* rtl/chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// chunked_body_decoder: chunked transfer-coding body decoder
// Front classifier and queue, decoder core, limit registers.
// ----------------------------------------------------------------------------
// Takes one raw body byte per clock while the two-entry queue has room and
// returns one result per byte: the decoded data byte when it is chunk data,
// and a status (in progress, complete, bad request, too large). The result
// is registered in the cycle after the decoder core takes the byte. Limit
// registers are written through wr_en/wr_index/wr_data; the user must write
// them only while idle, and the block does not enforce this.
`default_nettype none
module chunked_body_decoder import cbd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  cbd_in_if.sink           in_ch,
  cbd_out_if.source        out_ch,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [31:0] wr_data
);
  logic [31:0] max_data_bytes, max_message_bytes;
  logic [15:0] max_line_bytes, max_trailer_bytes;
  item_t       item;
  logic        item_valid, item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_data_bytes <= 32'd1048576;
      max_line_bytes <= 16'd8192;
      max_trailer_bytes <= 16'd8192;
      max_message_bytes <= 32'd16777216;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_BODY:    max_data_bytes <= wr_data;
        REG_MAX_LINE:    max_line_bytes <= wr_data[15:0];
        REG_MAX_TRAILER: max_trailer_bytes <= wr_data[15:0];
        REG_MAX_MESSAGE: max_message_bytes <= wr_data;
        default: ;
      endcase
    end
  end

  cbd_front u_front (
    .clk, .rst, .in_ch, .item, .item_valid, .item_ready
  );

  cbd_back u_back (
    .clk, .rst, .item, .item_valid, .item_ready,
    .max_data_bytes, .max_line_bytes, .max_trailer_bytes, .max_message_bytes,
    .out_ch
  );

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.body_valid |-> out_ch.body_byte == 8'h00)
    else $error("body_byte not zero without body_valid");
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.body_valid |-> out_ch.status == ST_BUSY)
    else $error("data byte with final status");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("result dropped under stall");
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: regression bench for the chunked body decoder
// Streams well-formed and corrupted chunked bodies through the input channel,
// predicts each per-byte result and checks it against the output channel
// under random sender bursts, receiver stalls and several limit settings.
// ----------------------------------------------------------------------------
module tb_top;
  import cbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam longint unsigned HUGE_SIZE = 64'd1 << 52;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic [1:0] status;
  } decode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_MAX_BODY;
  logic [31:0] wr_data = '0;

  cbd_in_if  in_ch ();
  cbd_out_if out_ch ();

  chunked_body_decoder dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [31:0]     lim_body, lim_line, lim_trailer, lim_message;
  phase_t          ph;
  bit              prev_cr;
  longint unsigned acc, chunk_left;
  int              digits, size_err;  // size_err: 0 none, 1 bad, 2 too large
  longint unsigned line_len, body_cnt, msg_cnt, trl_cnt;
  bit [1:0]        trl_flags;         // bit0 line started, bit1 colon seen

  decode_t decode_q[$];
  int      errors = 0;
  int      cycles = 0;

  logic [7:0] stream_q[$];
  bit         sob_q[$];
  int         burst_left = 8;
  int         gap_left = 0;

  function automatic void line_reset();
    prev_cr = 0; acc = 0; digits = 0; size_err = 0; line_len = 0;
  endfunction

  function automatic void body_reset();
    ph = PH_SIZE;
    line_reset();
    chunk_left = 0; body_cnt = 0; msg_cnt = 0; trl_cnt = 0; trl_flags = 0;
  endfunction

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit field_ok();
    if (digits == 0 || digits > MAX_HEX_DIGITS || size_err == 1) begin
      ph = PH_BAD;
      return 0;
    end
    if (size_err == 2) begin
      ph = PH_BIG;
      return 0;
    end
    return 1;
  endfunction

  function automatic void size_char(logic [7:0] c);
    int v;
    if (line_len + 1 > lim_line) begin
      ph = PH_BIG;
      return;
    end
    line_len++;
    if (ph == PH_EXT) return;
    if (c == CH_SEMI) begin
      if (field_ok()) ph = PH_EXT;
      return;
    end
    if (digits <= MAX_HEX_DIGITS) digits++;
    v = hex_of(c);
    if (v < 0) begin
      if (size_err == 0) size_err = 1;
    end else if (size_err == 0) begin
      acc = acc * 16 + v;
      if (acc > HUGE_SIZE) size_err = 2;
    end
  endfunction

  function automatic void size_eol();
    longint unsigned sz;
    if (ph == PH_SIZE && !field_ok()) return;
    sz = acc;
    line_reset();
    if (sz == 0) begin
      ph = PH_TRAILER;
      trl_flags = 0;
    end else if (body_cnt + sz > lim_body) begin
      ph = PH_BIG;
    end else begin
      chunk_left = sz;
      ph = PH_DATA;
    end
  endfunction

  function automatic void size_in(logic [7:0] b);
    if (b == CH_LF) begin
      if (!prev_cr) begin
        ph = PH_BAD;
        return;
      end
      prev_cr = 0;
      size_eol();
      return;
    end
    if (prev_cr) begin
      prev_cr = 0;
      size_char(CH_CR);
      if (ph != PH_SIZE && ph != PH_EXT) return;
    end
    if (b == CH_CR) prev_cr = 1;
    else size_char(b);
  endfunction

  function automatic bit trl_tick();
    if (trl_cnt + 1 > lim_trailer) begin
      ph = PH_BIG;
      return 0;
    end
    trl_cnt++;
    return 1;
  endfunction

  function automatic void trailer_in(logic [7:0] b);
    if (b == CH_LF) begin
      if (!prev_cr) begin
        ph = PH_BAD;
        return;
      end
      prev_cr = 0;
      if (!trl_flags[0]) begin
        ph = PH_DONE;
        return;
      end
      if (!trl_flags[1]) begin
        ph = PH_BAD;
        return;
      end
      if (!trl_tick()) return;
      trl_flags = 0;
      return;
    end
    if (prev_cr) begin
      prev_cr = 0;
      // a leading CR turned out to be line content
      if (!trl_flags[0]) begin
        trl_flags[0] = 1;
        if (!trl_tick()) return;
      end
    end
    if (b == CH_CR) begin
      if (trl_flags[0] && !trl_tick()) return;
      prev_cr = 1;
      return;
    end
    if (!trl_tick()) return;
    if (!trl_flags[0]) begin
      trl_flags[0] = 1;
      if (b == CH_SP || b == CH_HT || b == CH_COLON) begin
        ph = PH_BAD;
        return;
      end
    end
    if (b == CH_COLON) trl_flags[1] = 1;
  endfunction

  function automatic decode_t decode_byte(logic [7:0] b, bit sob);
    decode_t r;
    r = '0;
    if (sob) body_reset();
    if (ph < PH_DONE) begin
      if (msg_cnt + 1 > lim_message) begin
        ph = PH_BIG;
      end else begin
        msg_cnt++;
        case (ph)
          PH_SIZE, PH_EXT: size_in(b);
          PH_DATA: begin
            if (body_cnt + 1 > lim_body) begin
              ph = PH_BIG;
            end else begin
              r.body_valid = 1;
              r.body_byte = b;
              body_cnt++;
              if (chunk_left > 0) chunk_left--;
              if (chunk_left == 0) ph = PH_DATA_CR;
            end
          end
          PH_DATA_CR: ph = (b == CH_CR) ? PH_DATA_LF : PH_BAD;
          PH_DATA_LF: begin
            if (b == CH_LF) begin
              line_reset();
              ph = PH_SIZE;
            end else begin
              ph = PH_BAD;
            end
          end
          default: trailer_in(b);
        endcase
      end
    end
    case (ph)
      PH_DONE: r.status = ST_DONE;
      PH_BAD:  r.status = ST_BAD;
      PH_BIG:  r.status = ST_BIG;
      default: r.status = ST_BUSY;
    endcase
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    decode_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.body_valid, out_ch.body_byte, out_ch.status};
      if (decode_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = decode_q.pop_front();
        if (got.body_valid !== want.body_valid)
          $display("%0t: body_valid expected %h actual %h", $time, want.body_valid,
                   got.body_valid);
        if (got.body_byte !== want.body_byte)
          $display("%0t: body_byte expected %h actual %h", $time, want.body_byte,
                   got.body_byte);
        if (got.status !== want.status)
          $display("%0t: status expected %h actual %h", $time, want.status, got.status);
        if (got !== want) errors++;
      end
    end
  end

  // Receiver stall pattern: a randomly redrawn mode sets how ready is driven
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((cycles % 8) < 5);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, bit sob);
    @(negedge clk);
    if (gap_left > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    in_ch.start_of_body = sob;
    do @(posedge clk); while (!in_ch.ready);
    decode_q.insert(decode_q.size(), decode_byte(b, sob));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
    end
  endtask

  task automatic flush_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front(), sob_q.pop_front());
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic put(logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
    sob_q.insert(sob_q.size(), 1'b0);
  endtask

  task automatic put_str(string s);
    foreach (s[i]) put(s[i]);
  endtask

  task automatic start_body();
    sob_q[sob_q.size() - 1] = 1'b1;
  endtask

  task automatic put_crlf();
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic put_size(int unsigned n);
    string h;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) put("0");
    h = $sformatf("%0h", n);
    foreach (h[i]) put(($urandom_range(0, 1) && h[i] >= "a") ? h[i] - 8'h20 : h[i]);
    if ($urandom_range(0, 4) == 0) begin
      put(CH_SEMI);
      repeat ($urandom_range(0, 6)) put(8'($urandom_range(8'h21, 8'h7e)));
    end
    put_crlf();
  endtask

  // Build one chunked body, mostly well formed, sometimes broken
  task automatic build_body();
    int first, n, k;
    string odd_sizes[7] = '{"10000000000000", "10000000000001", "00000000000000001",
                            "0000000000000003", "", "1g", "20000000000000"};
    first = stream_q.size();
    n = $urandom_range(0, 3);
    for (int c = 0; c < n; c++) begin
      if ($urandom_range(0, 15) == 0) begin
        put_str(odd_sizes[$urandom_range(0, 6)]);
        put_crlf();
        k = 3;
      end else begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        put_size(k);
      end
      repeat (k) put(8'($urandom_range(0, 255)));
      put_crlf();
    end
    put_size(0);
    repeat ($urandom_range(0, 2)) begin
      put_str("X-t");
      put(CH_COLON);
      repeat ($urandom_range(0, 5)) put(8'($urandom_range(8'h20, 8'h7e)));
      put_crlf();
    end
    put_crlf();
    sob_q[first] = 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(first, stream_q.size() - 1);
      case ($urandom_range(0, 4))
        0: stream_q[k] = 8'($urandom_range(0, 255));
        1: stream_q[k] = CH_LF;
        2: stream_q[k] = CH_CR;
        3: stream_q[k] = CH_SP;
        default: stream_q[k] = CH_COLON;
      endcase
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    while (decode_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(posedge clk);
    case (idx)
      REG_MAX_BODY:    lim_body = val;
      REG_MAX_LINE:    lim_line = {16'd0, val[15:0]};
      REG_MAX_TRAILER: lim_trailer = {16'd0, val[15:0]};
      default:         lim_message = val;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic set_limits(logic [31:0] b, logic [31:0] l, logic [31:0] t, logic [31:0] m);
    wait_idle();
    write_reg(REG_MAX_BODY, b);
    write_reg(REG_MAX_LINE, l);
    write_reg(REG_MAX_TRAILER, t);
    write_reg(REG_MAX_MESSAGE, m);
  endtask

  task automatic test_directed();
    // extension, one data byte, trailer, end
    put("1");
    start_body();
    put_str(";x");
    put_crlf();
    put(8'hff);
    put_crlf();
    put("0");
    put_crlf();
    put_str("A:b");
    put_crlf();
    put_crlf();
    // bare LF
    put(CH_LF);
    start_body();
    // non-hex size
    put("G");
    start_body();
    put_crlf();
    put(8'h00);
    start_body();
    flush_stream();
  endtask

  task automatic test_random(int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_body();
      sent += stream_q.size();
      flush_stream();
    end
  endtask

  task automatic test_tight_limits();
    set_limits(32'd0, 32'd1, 32'd0, 32'd1);
    test_random(60);
    set_limits(32'd20, 32'd3, 32'd6, 32'd40);
    test_random(250);
    set_limits(32'hffff_ffff, 32'h0000_ffff, 32'h0000_ffff, 32'hffff_ffff);
    test_random(300);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.start_of_body = 1'b0;
    lim_body = 32'd1048576;
    lim_line = 32'd8192;
    lim_trailer = 32'd8192;
    lim_message = 32'd16777216;
    body_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(1000);
    test_tight_limits();
    set_limits(32'd1048576, 32'd8192, 32'd8192, 32'd16777216);
    test_random(150);

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
